>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("assertion failed: pre |-> post");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("assertion failed: pre |=> post");

`endif

>>> sv/sbd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbd_pkg
// Types, register map and arithmetic helpers of the spectral beat detector.
// ---------------------------------------------------------------------------
package sbd_pkg;

	localparam int unsigned ADDR_W   = 4;
	localparam int unsigned AVG_W    = 41;
	localparam int unsigned FAVG_W   = 31;
	localparam int unsigned ESUM_W   = 23;
	localparam int unsigned BAVG_O_W = 40;
	localparam int unsigned FAVG_O_W = 30;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_BIN_AVG_SHIFT   = 2'd0;
	localparam reg_idx_t REG_FRAME_AVG_SHIFT = 2'd1;
	localparam reg_idx_t REG_BEAT_RATIO      = 2'd2;

	localparam logic [3:0] BIN_AVG_SHIFT_RST   = 4'd4;
	localparam logic [3:0] FRAME_AVG_SHIFT_RST = 4'd5;
	localparam logic [7:0] BEAT_RATIO_RST      = 8'd32;

	localparam logic [ESUM_W-1:0] ESUM_MAX = {ESUM_W{1'b1}};

	// avg + floor((target - avg) / 2^sh); result lies between avg and target
	function automatic logic [AVG_W-1:0] ewma(input logic [AVG_W-1:0] avg,
	                                          input logic [AVG_W-1:0] target,
	                                          input logic [3:0] sh);
		logic signed [AVG_W:0] diff;
		logic signed [AVG_W:0] step;
		logic signed [AVG_W:0] sum;
		diff = $signed({1'b0, target}) - $signed({1'b0, avg});
		step = diff >>> sh;
		sum  = $signed({1'b0, avg}) + step;
		return sum[AVG_W-1:0];
	endfunction

endpackage

>>> sv/sbd_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbd_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module sbd_ram #(
	parameter int unsigned WIDTH = 41,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/spectral_beat_detector.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spectral_beat_detector
// Per-bin and per-frame energy beat detection over a stream of stereo bins.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one bin per word: left and right magnitudes in
//   s_tdata, s_tlast on the last bin of a frame. A frame also ends by itself
//   after BINS bins. Master stream returns one word per bin: bin index,
//   updated bin average, frame energy and frame average in m_tdata, the bin
//   and frame beat flags in m_tuser, m_tlast on the frame's last bin. Frame
//   fields are zero on all other words.
//   Accepted words pass stage registers s1 to s4 before m_tvalid. One word
//   per cycle is sustained while m_tready is high, bounded by the single
//   read-modify-write of the bin average memory per bin (read on accept,
//   written back in stage 1, forwarding back-to-back bins of one index).
//   After reset the average memory is cleared one entry a cycle, all BINS
//   entries, with s_tready low; the APB registers can be written meanwhile.
//   When m_tready is low with a word waiting, the whole pipeline holds and
//   s_tready drops; no word is lost or repeated.
//   Registers: 0x0 bin_avg_shift, 0x4 frame_avg_shift, 0x8 beat_ratio (Q4.4).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spectral_beat_detector #(
	parameter int unsigned BINS = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// APB register port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sbd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// input stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,  // [15:0] left_bin, [31:16] right_bin
	input  logic                       s_tlast,  // frame_end
	// result stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [7:0] bin_index, [47:8] bin_average, [70:48] frame_energy,
	// [100:71] frame_average, [103:101] zero
	output logic [103:0]               m_tdata,
	output logic [1:0]                 m_tuser,  // [0] bin_beat, [1] frame_beat
	output logic                       m_tlast   // last
);

	localparam int unsigned CW = $clog2(BINS);
	localparam int unsigned AW = sbd_pkg::AVG_W;
	localparam int unsigned FW = sbd_pkg::FAVG_W;
	localparam int unsigned EW = sbd_pkg::ESUM_W;

	// ---------------- configuration ----------------
	logic [3:0] bin_avg_shift_q;
	logic [3:0] frame_avg_shift_q;
	logic [7:0] beat_ratio_q;
	sbd_pkg::reg_idx_t reg_idx;
	logic cfg_we;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_we  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_avg_shift_q   <= sbd_pkg::BIN_AVG_SHIFT_RST;
			frame_avg_shift_q <= sbd_pkg::FRAME_AVG_SHIFT_RST;
			beat_ratio_q      <= sbd_pkg::BEAT_RATIO_RST;
		end else if (cfg_we) begin
			unique case (reg_idx)
				sbd_pkg::REG_BIN_AVG_SHIFT:   bin_avg_shift_q   <= pwdata[3:0];
				sbd_pkg::REG_FRAME_AVG_SHIFT: frame_avg_shift_q <= pwdata[3:0];
				sbd_pkg::REG_BEAT_RATIO:      beat_ratio_q      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			sbd_pkg::REG_BIN_AVG_SHIFT:   prdata = {28'd0, bin_avg_shift_q};
			sbd_pkg::REG_FRAME_AVG_SHIFT: prdata = {28'd0, frame_avg_shift_q};
			sbd_pkg::REG_BEAT_RATIO:      prdata = {24'd0, beat_ratio_q};
			default:                      prdata = 32'd0;
		endcase
	end

	// ---------------- control ----------------
	logic          clearing_q;
	logic [CW-1:0] clr_addr_q;
	logic [CW-1:0] bin_cnt_q;
	logic          advance;
	logic          in_acc;
	logic          in_last;

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign advance  = !valid_s4 || m_tready;
	assign s_tready = advance && !clearing_q;
	assign in_acc   = s_tvalid && s_tready;
	assign in_last  = s_tlast || (bin_cnt_q == CW'(BINS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			bin_cnt_q  <= '0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == CW'(BINS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (in_acc) begin
				bin_cnt_q <= in_last ? '0 : bin_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// ---------------- stage 0: power and right-channel energy ----------------
	logic signed [15:0] left_bin;
	logic signed [15:0] right_bin;
	logic signed [16:0] lr_sum;
	logic [16:0]        lr_mag;
	logic [33:0]        power;
	logic signed [7:0]  right_q;
	logic signed [15:0] right_sq;

	assign left_bin  = s_tdata[15:0];
	assign right_bin = s_tdata[31:16];
	assign lr_sum    = 17'(left_bin) + 17'(right_bin);
	assign lr_mag    = lr_sum[16] ? 17'(-lr_sum) : lr_sum;
	assign power     = lr_mag * lr_mag;
	assign right_q   = 8'(right_bin >>> 8);
	assign right_sq  = right_q * right_q;

	logic [CW-1:0] idx_s1;
	logic [AW-1:0] target_s1;
	logic [14:0]   rsq_s1;
	logic          last_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			idx_s1    <= bin_cnt_q;
			target_s1 <= {power[32:0], 8'd0};
			rsq_s1    <= right_sq[14:0];
			last_s1   <= in_last;
		end
	end

	// ---------------- stage 1: bin average read-modify-write ----------------
	logic [AW-1:0] ram_rdata;
	logic [AW-1:0] old_avg;
	logic [AW-1:0] new_avg;
	logic          ram_we;
	logic [CW-1:0] ram_waddr;
	logic [AW-1:0] ram_wdata;
	logic [EW:0]   esum_add;
	logic [EW-1:0] esum_new;
	logic [EW-1:0] esum_q;

	logic [CW-1:0] idx_s2;
	logic [AW-1:0] avg_s2;
	logic [AW-1:0] target_s2;
	logic [EW-1:0] esum_s2;
	logic          last_s2;

	// previous word wrote this entry on the edge this word was read: forward it
	assign old_avg = (valid_s2 && idx_s2 == idx_s1) ? avg_s2 : ram_rdata;
	assign new_avg = sbd_pkg::ewma(old_avg, target_s1, bin_avg_shift_q);

	assign ram_we    = clearing_q || (valid_s1 && advance);
	assign ram_waddr = clearing_q ? clr_addr_q : idx_s1;
	assign ram_wdata = clearing_q ? '0 : new_avg;

	sbd_ram #(
		.WIDTH(AW),
		.DEPTH(BINS)
	) u_avg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (bin_cnt_q),
		.rdata (ram_rdata)
	);

	assign esum_add = {1'b0, esum_q} + (EW + 1)'(rsq_s1);
	assign esum_new = esum_add[EW] ? sbd_pkg::ESUM_MAX : esum_add[EW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esum_q <= '0;
		end else if (valid_s1 && advance) begin
			esum_q <= last_s1 ? '0 : esum_new;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			idx_s2    <= idx_s1;
			avg_s2    <= new_avg;
			target_s2 <= target_s1;
			esum_s2   <= esum_new;
			last_s2   <= last_s1;
		end
	end

	// ---------------- stage 2: bin beat, frame average ----------------
	logic [AW+3:0]  avg_x9;
	logic           bin_beat;
	logic [AW-1:0]  favg_calc;
	logic [FW-1:0]  favg_new;
	logic [FW-1:0]  favg_q;

	assign avg_x9    = {avg_s2, 3'd0} + (AW + 4)'(avg_s2);
	assign bin_beat  = {4'd0, target_s2} > avg_x9;
	assign favg_calc = sbd_pkg::ewma({10'd0, favg_q}, {10'd0, esum_s2, 8'd0}, frame_avg_shift_q);
	assign favg_new  = favg_calc[FW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			favg_q <= '0;
		end else if (valid_s2 && last_s2 && advance) begin
			favg_q <= favg_new;
		end
	end

	logic [CW-1:0]                idx_s3;
	logic                         bin_beat_s3;
	logic [sbd_pkg::BAVG_O_W-1:0] bavg_s3;
	logic [EW-1:0]                esum_s3;
	logic [FW-1:0]                favg_s3;
	logic                         last_s3;

	always_ff @(posedge clk) begin
		if (advance) begin
			idx_s3      <= idx_s2;
			bin_beat_s3 <= bin_beat;
			bavg_s3     <= avg_s2[AW-1] ? '1 : avg_s2[sbd_pkg::BAVG_O_W-1:0];
			esum_s3     <= esum_s2;
			favg_s3     <= favg_new;
			last_s3     <= last_s2;
		end
	end

	// ---------------- stage 3: frame beat, output register ----------------
	logic [FW+7:0] ratio_prod;
	logic [FW+7:0] esum_scaled;
	logic          frame_beat;
	logic [CW+7:0] idx_wide;

	assign ratio_prod  = beat_ratio_q * favg_s3;
	assign esum_scaled = (FW + 8)'({esum_s3, 12'd0});
	assign frame_beat  = last_s3 && (esum_scaled > ratio_prod);
	assign idx_wide    = {8'd0, idx_s3};

	logic [7:0]                   idx_s4;
	logic                         bin_beat_s4;
	logic [sbd_pkg::BAVG_O_W-1:0] bavg_s4;
	logic [EW-1:0]                fenergy_s4;
	logic [sbd_pkg::FAVG_O_W-1:0] favg_s4;
	logic                         frame_beat_s4;
	logic                         last_s4;

	always_ff @(posedge clk) begin
		if (advance) begin
			idx_s4        <= idx_wide[7:0];
			bin_beat_s4   <= bin_beat_s3;
			bavg_s4       <= bavg_s3;
			fenergy_s4    <= last_s3 ? esum_s3 : '0;
			if (!last_s3) begin
				favg_s4 <= '0;
			end else if (favg_s3[FW-1]) begin
				favg_s4 <= '1;
			end else begin
				favg_s4 <= favg_s3[sbd_pkg::FAVG_O_W-1:0];
			end
			frame_beat_s4 <= frame_beat;
			last_s4       <= last_s3;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {3'd0, favg_s4, fenergy_s4, bavg_s4, idx_s4};
	assign m_tuser  = {frame_beat_s4, bin_beat_s4};
	assign m_tlast  = last_s4;

	// ---------------- assertions ----------------
	`ASSERT_IMPLIES(a_no_accept_while_clearing, clk, arst_n, clearing_q, !s_tready)
	`ASSERT_IMPLIES(a_clear_before_traffic, clk, arst_n, clearing_q, !valid_s1 && !valid_s4)
	`ASSERT_IMPLIES(a_frame_fields_zero, clk, arst_n, m_tvalid && !m_tlast,
		m_tdata[100:48] == '0 && !m_tuser[1])
	`ASSERT_NEXT(a_counter_restarts, clk, arst_n, in_acc && in_last, bin_cnt_q == '0)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for spectral_beat_detector. Streams stereo bins in
// short frames, noisy frames and one full-scale overrun frame under several
// register settings, predicts every result word from its own copy of the
// per-bin and per-frame averages, and checks the result stream in order.
// ---------------------------------------------------------------------------
module testbench;

	localparam int BINS = 256;

	typedef struct {
		logic [7:0]  bin_index;
		logic        bin_beat;
		logic [39:0] bin_average;
		logic [22:0] frame_energy;
		logic [29:0] frame_average;
		logic        frame_beat;
		logic        lst;
	} bin_result_t;

	class beat_scoreboard;
		logic [40:0]  bin_avg_mem [BINS];
		logic [7:0]   bin_pos;
		logic [22:0]  energy_acc;
		logic [30:0]  frame_avg_acc;
		logic [3:0]   bin_shift;
		logic [3:0]   frame_shift;
		logic [7:0]   ratio;
		bin_result_t  awaited[$];
		int unsigned  errors;

		function new();
			foreach (bin_avg_mem[i]) bin_avg_mem[i] = '0;
			bin_pos       = '0;
			energy_acc    = '0;
			frame_avg_acc = '0;
			bin_shift     = sbd_pkg::BIN_AVG_SHIFT_RST;
			frame_shift   = sbd_pkg::FRAME_AVG_SHIFT_RST;
			ratio         = sbd_pkg::BEAT_RATIO_RST;
			errors        = 0;
		endfunction

		function void set_reg(sbd_pkg::reg_idx_t idx, logic [31:0] val);
			case (idx)
				sbd_pkg::REG_BIN_AVG_SHIFT: bin_shift = val[3:0];
				sbd_pkg::REG_FRAME_AVG_SHIFT: frame_shift = val[3:0];
				sbd_pkg::REG_BEAT_RATIO: ratio = val[7:0];
				default: ;
			endcase
		endfunction

		// move avg toward target by (target - avg) / 2^sh, rounding down
		function logic [63:0] smooth(logic [63:0] avg, logic [63:0] target, logic [3:0] sh);
			logic signed [65:0] diff;
			logic signed [65:0] res;
			diff = $signed({2'b00, target}) - $signed({2'b00, avg});
			res  = $signed({2'b00, avg}) + (diff >>> sh);
			return res[63:0];
		endfunction

		function void note_bin(logic [15:0] left, logic [15:0] right, logic fend);
			logic signed [16:0] sum;
			logic [16:0]        mag;
			logic [63:0]        pw;
			logic [63:0]        avg;
			logic [63:0]        e;
			logic [63:0]        favg;
			logic signed [7:0]  rq;
			logic [15:0]        rq2;
			logic [23:0]        acc;
			bin_result_t        want;
			sum = $signed(left) + $signed(right);
			mag = (sum < 0) ? -sum : sum;
			pw  = 64'(mag);
			pw  = pw * pw;
			avg = smooth({23'd0, bin_avg_mem[bin_pos]}, pw << 8, bin_shift);
			bin_avg_mem[bin_pos] = avg[40:0];

			rq  = 8'($signed(right) >>> 8);
			rq2 = rq * rq;
			acc = energy_acc + rq2;
			energy_acc = (acc > sbd_pkg::ESUM_MAX) ? sbd_pkg::ESUM_MAX : acc[22:0];

			want.bin_index     = bin_pos;
			want.bin_beat      = (pw << 8) > 9 * avg;
			want.bin_average   = (avg > 64'hFF_FFFF_FFFF) ? '1 : avg[39:0];
			want.frame_energy  = '0;
			want.frame_average = '0;
			want.frame_beat    = 1'b0;
			want.lst           = fend || (bin_pos == 8'(BINS - 1));
			if (want.lst) begin
				e    = 64'(energy_acc);
				favg = smooth({33'd0, frame_avg_acc}, e << 8, frame_shift);
				frame_avg_acc      = favg[30:0];
				want.frame_energy  = e[22:0];
				want.frame_average = (favg > 64'h3FFF_FFFF) ? '1 : favg[29:0];
				want.frame_beat    = (e << 12) > ratio * favg;
				energy_acc = '0;
				bin_pos    = '0;
			end else begin
				bin_pos = bin_pos + 8'd1;
			end
			awaited.push_back(want);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("%0t: mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
			errors++;
		endtask

		task compare(string what, logic [63:0] got, logic [63:0] want);
			if (got !== want) report(what, got, want);
		endtask

		task check_bin(logic [103:0] data, logic [1:0] user, logic lst);
			bin_result_t want;
			if (awaited.size() == 0) begin
				report("word with nothing expected", data[63:0], '0);
				return;
			end
			want = awaited.pop_front();
			compare("bin_index", 64'(data[7:0]), 64'(want.bin_index));
			compare("bin_average", 64'(data[47:8]), 64'(want.bin_average));
			compare("frame_energy", 64'(data[70:48]), 64'(want.frame_energy));
			compare("frame_average", 64'(data[100:71]), 64'(want.frame_average));
			compare("bin_beat", 64'(user[0]), 64'(want.bin_beat));
			compare("frame_beat", 64'(user[1]), 64'(want.frame_beat));
			compare("last", 64'(lst), 64'(want.lst));
		endtask
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [sbd_pkg::ADDR_W-1:0]  paddr = '0;
	logic [31:0]                 pwdata = '0;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [31:0]                 s_tdata = '0;  // [15:0] left_bin, [31:16] right_bin
	logic                        s_tlast = 1'b0;  // frame_end
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	// [7:0] bin_index, [47:8] bin_average, [70:48] frame_energy,
	// [100:71] frame_average, [103:101] zero
	logic [103:0]                m_tdata;
	logic [1:0]                  m_tuser;  // [0] bin_beat, [1] frame_beat
	logic                        m_tlast;

	bit                          calm = 1'b0;
	beat_scoreboard              sb = new();

	spectral_beat_detector #(.BINS(BINS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	function automatic bit idle_roll();
		return !calm && ($urandom_range(0, 99) < 6);
	endfunction

	function automatic logic [15:0] rand_mag();
		int unsigned v;
		v = $urandom_range(0, 8);
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2, 3: return v[15:0] - 16'd4;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic apb_write(sbd_pkg::reg_idx_t idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic push_word(logic [15:0] left, logic [15:0] right, logic fend);
		while (idle_roll()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {right, left};
		s_tlast  <= fend;
		do @(posedge clk); while (!s_tready);
		sb.note_bin(left, right, fend);
	endtask

	task automatic stop_stream();
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
	endtask

	// drain the result stream, then allow for the pipeline latency
	task automatic wait_drained();
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_frames(int budget);
		int sent;
		int len;
		bit noisy;
		sent = 0;
		while (sent < budget) begin
			noisy = ($urandom_range(0, 99) < 20);
			len = noisy ? $urandom_range(1, 8) : $urandom_range(1, 24);
			for (int k = 0; k < len; k++) begin
				if (noisy)
					push_word(rand_mag(), rand_mag(), $urandom_range(0, 99) < 30);
				else
					push_word(rand_mag(), rand_mag(), k == len - 1);
			end
			sent += len;
		end
		stop_stream();
	endtask

	// result side: check accepted words, stall now and then
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_bin(m_tdata, m_tuser, m_tlast);
			m_tready <= !idle_roll();
		end
	end

	initial begin
		#2_000_000;
		$display("testbench failed");
		$finish;
	end

	initial begin
		logic [3:0] bs;
		logic [3:0] fs;
		logic [7:0] br;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed bins under reset settings
		push_word(16'd0, 16'd0, 1'b0);
		push_word(16'd1, 16'd0, 1'b0);
		push_word(16'h7FFF, 16'h7FFF, 1'b0);
		push_word(16'h8000, 16'h8000, 1'b0);
		push_word(16'h7FFF, 16'h8000, 1'b0);
		push_word(16'h8000, 16'h7FFF, 1'b0);
		push_word(16'hFFFF, 16'hFFFF, 1'b0);
		push_word(16'd255, 16'd255, 1'b0);
		push_word(-16'sd256, -16'sd257, 1'b0);
		push_word(16'd0, 16'hFFFF, 1'b1);
		push_word(16'd5, 16'd5, 1'b1);
		push_word(16'h8000, 16'h8000, 1'b1);
		push_word(16'd100, -16'sd100, 1'b0);
		push_word(16'h5555, 16'hAAAA, 1'b0);
		push_word(16'hAAAA, 16'h5555, 1'b1);
		stop_stream();
		wait_drained();

		// fastest averaging: a full-scale frame saturates both averages,
		// and its bin 255 closes the frame without frame_end
		apb_write(sbd_pkg::REG_BIN_AVG_SHIFT, 32'd0);
		apb_write(sbd_pkg::REG_FRAME_AVG_SHIFT, 32'd0);
		apb_write(sbd_pkg::REG_BEAT_RATIO, 32'd255);
		push_word(16'd0, 16'd0, 1'b1);
		for (int k = 0; k < BINS; k++)
			push_word(16'h8000, 16'h8000, 1'b0);
		random_frames(100);
		wait_drained();

		apb_write(sbd_pkg::REG_BIN_AVG_SHIFT, 32'd8);
		apb_write(sbd_pkg::REG_FRAME_AVG_SHIFT, 32'd8);
		apb_write(sbd_pkg::REG_BEAT_RATIO, 32'd0);
		random_frames(100);
		wait_drained();

		// shifts past the nominal range, no stalls on either side
		calm = 1'b1;
		apb_write(sbd_pkg::REG_BIN_AVG_SHIFT, 32'd15);
		apb_write(sbd_pkg::REG_FRAME_AVG_SHIFT, 32'd15);
		apb_write(sbd_pkg::REG_BEAT_RATIO, 32'd16);
		random_frames(100);
		wait_drained();
		calm = 1'b0;

		apb_write(sbd_pkg::REG_BIN_AVG_SHIFT, 32'd9);
		apb_write(sbd_pkg::REG_FRAME_AVG_SHIFT, 32'd3);
		apb_write(sbd_pkg::REG_BEAT_RATIO, 32'd128);
		random_frames(100);
		wait_drained();

		for (int ph = 0; ph < 2; ph++) begin
			bs = 4'($urandom_range(0, 15));
			fs = 4'($urandom_range(0, 15));
			br = 8'($urandom_range(0, 255));
			apb_write(sbd_pkg::REG_BIN_AVG_SHIFT, {28'd0, bs});
			apb_write(sbd_pkg::REG_FRAME_AVG_SHIFT, {28'd0, fs});
			apb_write(sbd_pkg::REG_BEAT_RATIO, {24'd0, br});
			random_frames(100);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
